>>> rtl/slhb_pkg.sv
// package: types and constants for the serial line history buffer
package slhb_pkg;

  localparam int unsigned MaxLineBytes = 64;
  localparam int unsigned HistDepth    = 8;
  localparam int unsigned SlotW        = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int unsigned LenW         = $clog2(MaxLineBytes);
  localparam int unsigned PartDepth    = MaxLineBytes - 1;
  localparam int unsigned PartIdxW     = (PartDepth > 1) ? $clog2(PartDepth) : 1;
  localparam int unsigned MemDepth     = HistDepth * MaxLineBytes;
  localparam int unsigned MemAddrW     = $clog2(MemDepth);

  localparam logic [7:0] CharCr = 8'h0d;
  localparam logic [7:0] CharLf = 8'h0a;

  typedef enum logic [2:0] {
    CmdRecv    = 3'd0,
    CmdPeek    = 3'd1,
    CmdRead    = 3'd2,
    CmdRemove  = 3'd3,
    CmdClear   = 3'd4,
    CmdDiscard = 3'd5,
    CmdPeekPar = 3'd6,
    CmdNone    = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StCommit,
    StLineRd,
    StLineOut,
    StShift,
    StParScan,
    StParOut
  } state_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] rx_byte;
    logic [3:0] line_index;
  } in_word_t;

  typedef struct packed {
    logic       found;
    logic       char_valid;
    logic [7:0] out_char;
    logic       last;
    logic [3:0] line_count;
    logic [5:0] partial_length;
    logic       line_committed;
  } out_word_t;

  // load and rotate control for the partial line cell chain
  typedef struct packed {
    logic                load;
    logic [PartIdxW-1:0] load_idx;
    logic [7:0]          load_byte;
    logic                rotate;
  } chain_ctl_t;

endpackage

>>> rtl/slhb_cell.sv
// one byte cell of the partial line chain
module slhb_cell import slhb_pkg::*; (
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       shift_i,
  input  logic [7:0] load_byte_i,
  input  logic [7:0] next_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q, byte_d;

  // take a new byte written here, or the neighbour's byte on a rotate
  always_comb begin
    byte_d = byte_q;
    if (load_i) begin
      byte_d = load_byte_i;
    end else if (shift_i) begin
      byte_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

>>> rtl/slhb_chain.sv
// partial line held as a rotating chain of byte cells, head at cell 0
module slhb_chain import slhb_pkg::*; (
  input  logic       clk_i,
  input  chain_ctl_t ctl_i,
  output logic [7:0] head_o
);

  logic [7:0] cell_byte [PartDepth];

  // a load writes the byte into the cell at its index, a rotate moves head to tail
  for (genvar g = 0; g < PartDepth; g++) begin : g_cell
    logic [7:0] nxt;
    logic       ld;
    if (g == PartDepth - 1) begin : g_tail
      assign nxt = cell_byte[0];
    end else begin : g_mid
      assign nxt = cell_byte[g+1];
    end
    assign ld = ctl_i.load && (ctl_i.load_idx == PartIdxW'(g));
    slhb_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (ld),
      .shift_i    (ctl_i.rotate),
      .load_byte_i(ctl_i.load_byte),
      .next_i     (nxt),
      .byte_o     (cell_byte[g])
    );
  end

  assign head_o = cell_byte[0];

endmodule

>>> rtl/serial_line_history_buffer_core.sv
// top level: serial line history buffer with a ring of stored lines
//
// One command word is accepted when start_i is high and busy_o is low.
// Each result is marked by res_valid_o for a single
// cycle; res_o.last flags the final result of a command. The receiver
// cannot stall, so results are never held back.
// The partial line lives in a row of byte cells that rotate one place a
// cycle when told to rotate; the stored lines sit in one memory with one
// read and one write port. A plain byte is answered through the
// registered result word after the accept. A line feed writes each
// partial byte into the new slot, with one rotation of the cell row per
// byte. Peeks give each character (at least one) through the registered
// memory read. A removal copies every newer line down a whole slot of
// MaxLineBytes bytes, reading each byte and then writing it; a read
// streams its line first and then does the same copy.
// Peek partial rotates the full row twice and keeps busy_o high until
// the second rotation ends.
// Reset clears the counters, so the ring and partial line start empty;
// the stored bytes are left as they were and a removal may copy unwritten ones.
module serial_line_history_buffer_core import slhb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_word_t  cmd_i,
  output logic      busy_o,
  output logic      res_valid_o,
  output out_word_t res_o
);

  state_e state_q, state_d;
  in_word_t cmd_q;
  logic [SlotW-1:0] newest_q, newest_d;
  logic [3:0]       held_q, held_d;
  logic [LenW-1:0]  pcount_q, pcount_d;
  logic [LenW-1:0]  cnt_q, cnt_d;    // byte position in the walk
  logic [LenW-1:0]  len_q, len_d;    // length of line being streamed or moved
  logic [SlotW-1:0] slot_q, slot_d;  // slot being streamed or filled
  logic             zero_q, zero_d;  // zero byte seen while scanning
  logic [LenW-1:0]  nz_q, nz_d;      // bytes before the first zero
  logic             phase_q, phase_d;

  logic [7:0]       mem [MemDepth];
  logic [LenW-1:0]  lens [HistDepth];
  logic [7:0]       rd_q;
  logic             mem_we, mem_re, len_we;
  logic [MemAddrW-1:0] wr_addr, rd_addr;
  logic [7:0]       wr_byte;
  logic [SlotW-1:0] len_slot;
  logic [LenW-1:0]  len_val;

  chain_ctl_t       ctl;
  logic [7:0]       head;

  logic       rv;
  out_word_t  r;
  logic       accept;

  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);

  slhb_chain u_chain (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .head_o(head)
  );

  // line memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_byte;
    if (mem_re) rd_q <= mem[rd_addr];
    if (len_we) lens[len_slot] <= len_val;
  end

  function automatic logic [SlotW-1:0] slot_add(logic [SlotW-1:0] a, logic [4:0] b);
    logic [5:0] s;
    s = 6'(a) + 6'(b);
    return SlotW'(s % HistDepth);
  endfunction

  function automatic logic [SlotW-1:0] slot_sub(logic [SlotW-1:0] a, logic [3:0] b);
    logic [5:0] s;
    s = 6'(a) + 6'(HistDepth) - 6'(b);
    return SlotW'(s % HistDepth);
  endfunction

  function automatic logic [MemAddrW-1:0] addr_of(logic [SlotW-1:0] s, logic [LenW-1:0] c);
    return MemAddrW'(s) * MemAddrW'(MaxLineBytes) + MemAddrW'(c);
  endfunction

  // next state and datapath control
  always_comb begin
    state_d = state_q; newest_d = newest_q; held_d = held_q; pcount_d = pcount_q;
    cnt_d = cnt_q; len_d = len_q; slot_d = slot_q; zero_d = zero_q; nz_d = nz_q;
    phase_d = phase_q;
    ctl = '0; mem_we = 1'b0; mem_re = 1'b0; len_we = 1'b0;
    wr_addr = addr_of(slot_q, cnt_q); rd_addr = addr_of(slot_q, cnt_q);
    wr_byte = head; len_slot = slot_q; len_val = nz_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cnt_d = '0; zero_d = 1'b0; nz_d = '0; phase_d = 1'b0;
          unique case (cmd_e'(cmd_i.command))
            CmdRecv: begin
              if (cmd_i.rx_byte == CharLf) begin
                state_d = StCommit;
                slot_d  = slot_add(newest_q, 5'd1);
              end else if (cmd_i.rx_byte != CharCr && 32'(pcount_q) < PartDepth) begin
                ctl.load = 1'b1; ctl.load_byte = cmd_i.rx_byte;
                ctl.load_idx = PartIdxW'(pcount_q);
                pcount_d = pcount_q + 1'b1;
              end
            end
            CmdPeek, CmdRead, CmdRemove: begin
              if (cmd_i.line_index < held_q) begin
                slot_d = slot_sub(newest_q, cmd_i.line_index);
                len_d  = lens[slot_sub(newest_q, cmd_i.line_index)];
                state_d = (cmd_e'(cmd_i.command) == CmdRemove) ? StShift : StLineRd;
              end
            end
            CmdClear: begin
              newest_d = '0; held_d = '0; pcount_d = '0;
            end
            CmdDiscard: pcount_d = '0;
            CmdPeekPar: if (pcount_q != '0) state_d = StParScan;
            default: ;
          endcase
        end
      end
      // write partial bytes into the new slot while rotating the chain
      StCommit: begin
        if (cnt_q == pcount_q) begin
          len_we = 1'b1;
          len_val = zero_q ? nz_q : pcount_q;
          newest_d = slot_q;
          if (32'(held_q) < HistDepth) held_d = held_q + 1'b1;
          pcount_d = '0;
          state_d = StIdle;
        end else begin
          mem_we = 1'b1; ctl.rotate = 1'b1;
          if (head == 8'd0 && !zero_q) begin
            zero_d = 1'b1; nz_d = cnt_q;
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
      // issue a read, then show the character
      StLineRd: begin
        mem_re = 1'b1;
        state_d = StLineOut;
      end
      StLineOut: begin
        if (len_q == '0 || cnt_q + 1'b1 == len_q) begin
          if (cmd_e'(cmd_q.command) == CmdRead) begin
            state_d = StShift; cnt_d = '0; phase_d = 1'b0;
            len_d = lens[slot_add(slot_q, 5'd1)];
          end else state_d = StIdle;
        end else begin
          cnt_d = cnt_q + 1'b1; state_d = StLineRd;
        end
      end
      // copy the next newer line down into this slot, reading a byte and then writing it
      StShift: begin
        if (slot_q == newest_q) begin
          newest_d = slot_sub(newest_q, 4'd1);
          held_d = held_q - 1'b1;
          state_d = StIdle;
        end else if (!phase_q) begin
          rd_addr = addr_of(slot_add(slot_q, 5'd1), cnt_q);
          mem_re = 1'b1;
          phase_d = 1'b1;
          if (cnt_q == '0) len_d = lens[slot_add(slot_q, 5'd1)];
        end else begin
          mem_we = 1'b1; wr_byte = rd_q; phase_d = 1'b0;
          if (32'(cnt_q) == MaxLineBytes - 1) begin
            len_we = 1'b1; len_val = len_q;
            cnt_d = '0; slot_d = slot_add(slot_q, 5'd1);
          end else cnt_d = cnt_q + 1'b1;
        end
      end
      // find bytes before the first zero, rotating the whole chain once
      StParScan: begin
        ctl.rotate = 1'b1;
        if (head == 8'd0 && !zero_q) begin
          zero_d = 1'b1; nz_d = cnt_q;
        end
        if (32'(cnt_q) == PartDepth - 1) begin
          cnt_d = '0;
          len_d = (zero_d && nz_d < pcount_q) ? nz_d : pcount_q;
          state_d = StParOut;
        end else cnt_d = cnt_q + 1'b1;
      end
      // stream bytes from the head, then rotate back to the start
      StParOut: begin
        ctl.rotate = 1'b1;
        if (32'(cnt_q) == PartDepth - 1) begin
          cnt_d = '0; state_d = StIdle;
        end else cnt_d = cnt_q + 1'b1;
      end
      default: state_d = StIdle;
    endcase
  end

  // result word
  always_comb begin
    rv = 1'b0; r = '0;
    r.line_count = held_q; r.partial_length = pcount_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (cmd_e'(cmd_i.command))
            CmdRecv: begin
              rv = (cmd_i.rx_byte != CharLf);
              r.last = 1'b1; r.partial_length = pcount_d;
            end
            CmdPeek, CmdRead: begin
              rv = !(cmd_i.line_index < held_q); r.last = 1'b1;
            end
            CmdRemove: begin
              rv = !(cmd_i.line_index < held_q); r.last = 1'b1;
            end
            CmdClear, CmdDiscard: begin
              rv = 1'b1; r.last = 1'b1;
              r.line_count = held_d; r.partial_length = '0;
            end
            CmdPeekPar: begin
              rv = (pcount_q == '0); r.last = 1'b1;
            end
            default: begin
              rv = 1'b1; r.last = 1'b1;
            end
          endcase
        end
      end
      StCommit: begin
        if (cnt_q == pcount_q) begin
          rv = 1'b1; r.last = 1'b1; r.line_committed = 1'b1;
          r.line_count = held_d; r.partial_length = '0;
        end
      end
      StLineOut: begin
        rv = 1'b1; r.found = 1'b1;
        r.char_valid = (len_q != '0);
        r.out_char = (len_q != '0) ? rd_q : 8'd0;
        r.last = (len_q == '0 || cnt_q + 1'b1 == len_q);
        if (cmd_e'(cmd_q.command) == CmdRead) r.line_count = held_q - 1'b1;
      end
      StShift: begin
        if (slot_q == newest_q && cmd_e'(cmd_q.command) == CmdRemove) begin
          rv = 1'b1; r.found = 1'b1; r.last = 1'b1; r.line_count = held_d;
        end
      end
      StParOut: begin
        if (len_q == '0) begin
          rv = (cnt_q == '0); r.found = 1'b1; r.last = 1'b1;
        end else if (cnt_q < len_q) begin
          rv = 1'b1; r.found = 1'b1; r.char_valid = 1'b1; r.out_char = head;
          r.last = (cnt_q + 1'b1 == len_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; newest_q <= '0; held_q <= '0; pcount_q <= '0;
      cnt_q <= '0; phase_q <= 1'b0; res_valid_o <= 1'b0;
    end else begin
      state_q <= state_d; newest_q <= newest_d; held_q <= held_d;
      pcount_q <= pcount_d; cnt_q <= cnt_d; phase_q <= phase_d;
      res_valid_o <= rv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= cmd_i;
    len_q <= len_d; slot_q <= slot_d; zero_q <= zero_d; nz_q <= nz_d;
    res_o <= r;
  end

`ifndef ASSERT_OFF
  a_held_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(held_q) <= HistDepth) else $error("line count above depth");
  a_part_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pcount_q) <= PartDepth) else $error("partial count above limit");
  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |=> !(res_valid_o && $past(accept)))
    else $error("accepted while busy");
`endif

endmodule
